FILE: rtl/pbn_pkg.sv
// pbn_pkg: shared constants and types for the pose blend pipeline
// no dependencies; used by pose_blend_nlerp
`timescale 1ns / 1ps
`default_nettype none

package pbn_pkg;

    // component layout
    localparam int CW       = 16;          // bits per component
    localparam int VEC_N    = 3;           // x,y,z
    localparam int QUAT_N   = 4;           // w,x,y,z
    localparam int VEC_W    = CW * VEC_N;  // 48
    localparam int QUAT_W   = CW * QUAT_N; // 64
    localparam int QFRAC    = CW - 2;      // quaternion fraction bits

    // weights, Q1.15
    localparam int          WT_W       = 16;
    localparam logic [15:0] WEIGHT_ONE = 16'h8000;

    // normalization datapath widths
    localparam int MAG_W  = 17;            // |lerped quaternion component|
    localparam int SUM_W  = 34;            // sum of squares, even width
    localparam int ROOT_W = SUM_W / 2;     // floor sqrt
    localparam int QUO_W  = QFRAC + 1;     // normalized magnitude
    localparam int NUM_W  = MAG_W + QFRAC; // rounded numerator
    localparam logic [QUO_W-1:0] QUO_MAX = QUO_W'(1) << QFRAC;

    // beat widths
    localparam int IN_W  = 2 * (2 * VEC_W + QUAT_W) + WT_W; // 336
    localparam int OUT_W = 2 * VEC_W + QUAT_W;             // 160

    // finished vectors and the pass-through rotation that ride along the pipe
    typedef struct packed {
        logic              pass;
        logic [VEC_W-1:0]  trans;
        logic [VEC_W-1:0]  scale;
        logic [QUAT_W-1:0] prot;
    } t_side;

    // side data that travels alongside the square root and the dividers
    typedef struct packed {
        t_side                         side;
        logic                          zero;
        logic [QUAT_N-1:0]             sign;
        logic [QUAT_N-1:0][MAG_W-1:0]  mag;
    } t_rot_side;

endpackage

`default_nettype wire

FILE: rtl/pbn_delay.sv
// pbn_delay: enable-gated shift line that keeps side data aligned with a pipelined unit
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module pbn_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_q
);

    logic [W-1:0] r_tap [DEPTH];

    // shift one place per advancing cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/pbn_isqrt.sv
// pbn_isqrt: pipelined floor square root, one root bit per stage
// no package dependency; instantiated by pose_blend_nlerp
`timescale 1ns / 1ps
`default_nettype none

module pbn_isqrt #(
    parameter int IN_W  = 34,
    parameter int OUT_W = IN_W / 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [IN_W-1:0]  i_x,
    output logic                  o_valid,
    output logic      [OUT_W-1:0] o_root
);

    localparam int TW = IN_W + 2;

    logic [IN_W-1:0]  r_rem   [OUT_W];
    logic [OUT_W-1:0] r_root  [OUT_W];
    logic [OUT_W-1:0] r_valid;

    // valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[OUT_W-2:0], i_valid};
        end
    end

    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        localparam int J = OUT_W - 1 - s;
        logic [IN_W-1:0]  rem_in;
        logic [OUT_W-1:0] root_in;
        logic [TW-1:0]    trial;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in  = i_x;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        // try setting root bit J: subtract 2*root*2^J + 2^(2J)
        assign trial = (TW'(root_in) << (J + 1)) + (TW'(1) << (2 * J));
        assign take  = TW'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= take ? rem_in - trial[IN_W-1:0] : rem_in;
                r_root[s] <= take ? (root_in | (OUT_W'(1) << J)) : root_in;
            end
        end
    end

    assign o_valid = r_valid[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];

    // an exact floor root leaves a remainder of at most twice the root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (TW'(r_rem[OUT_W-1]) <= (TW'(o_root) << 1)))
        else $error("isqrt remainder exceeds twice the root");

endmodule

`default_nettype wire

FILE: rtl/pbn_div.sv
// pbn_div: pipelined restoring divider, one quotient bit per stage
// no package dependency; instantiated by pose_blend_nlerp
`timescale 1ns / 1ps
`default_nettype none

module pbn_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 17,
    parameter int QUO_W = 15
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_valid,
    output logic      [QUO_W-1:0] o_quo
);

    localparam int TW = NUM_W + DEN_W;

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_valid;

    // valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QUO_W-2:0], i_valid};
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int J = QUO_W - 1 - s;
        logic [NUM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W-1:0] den_in;
        logic [TW-1:0]    shifted;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
        end

        // compare against the divisor at this bit weight
        assign shifted = TW'(den_in) << J;
        assign take    = TW'(rem_in) >= shifted;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= take ? rem_in - shifted[NUM_W-1:0] : rem_in;
                r_quo[s] <= take ? (quo_in | (QUO_W'(1) << J)) : quo_in;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];

    // a nonzero divisor always leaves a remainder below itself
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_den[QUO_W-1] != '0)) |->
            (TW'(r_rem[QUO_W-1]) < TW'(r_den[QUO_W-1])))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

FILE: rtl/pose_blend_nlerp.sv
// pose_blend_nlerp: per-bone pose blend, lerp of vectors and shortest-path nlerp of rotation
// depends on pbn_pkg, pbn_delay, pbn_isqrt, pbn_div
//
// channel   dir  width  fields (lowest bit first)
// s stream  in   336    a_translation, a_scale, a_rotation, b_translation,
//                        b_scale, b_rotation, mask_weight
// m stream  out  160    out_translation, out_scale, out_rotation
// cfg       in   16     blend_weight, written when i_cfg_we is high
//
// one bone per cycle unless the output stalls
// the pipe holds the 17-stage square root and the 15-stage dividers
// the whole pipe advances when the output register is empty or taken
// a stall freezes every stage, valid bits included
// synchronous active-low reset clears valid bits and sets blend_weight to one
`timescale 1ns / 1ps
`default_nettype none

module pose_blend_nlerp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    // a_translation, a_scale, a_rotation, b_translation, b_scale, b_rotation, mask_weight
    input  wire logic [pbn_pkg::IN_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    // out_translation, out_scale, out_rotation
    output logic [pbn_pkg::OUT_W-1:0]     o_m_tdata,
    input  wire logic                     i_cfg_we,
    input  wire logic [pbn_pkg::WT_W-1:0] i_cfg_wdata
);

    localparam int CW     = pbn_pkg::CW;
    localparam int VEC_W  = pbn_pkg::VEC_W;
    localparam int QUAT_W = pbn_pkg::QUAT_W;
    localparam int MAG_W  = pbn_pkg::MAG_W;
    localparam int SUM_W  = pbn_pkg::SUM_W;
    localparam int ROOT_W = pbn_pkg::ROOT_W;
    localparam int QUO_W  = pbn_pkg::QUO_W;
    localparam int NUM_W  = pbn_pkg::NUM_W;
    localparam int RS_W   = $bits(pbn_pkg::t_rot_side);

    // field offsets in the input beat
    localparam int O_AT = 0;
    localparam int O_AS = O_AT + VEC_W;
    localparam int O_AR = O_AS + VEC_W;
    localparam int O_BT = O_AR + QUAT_W;
    localparam int O_BS = O_BT + VEC_W;
    localparam int O_BR = O_BS + VEC_W;
    localparam int O_MW = O_BR + QUAT_W;

    logic en;

    // configuration register
    logic [15:0] r_blend_weight;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight <= pbn_pkg::WEIGHT_ONE;
        end else if (i_cfg_we) begin
            r_blend_weight <= i_cfg_wdata;
        end
    end

    // global advance: output register empty or being taken
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // ---------------- stage 1: blend factor ----------------
    logic [15:0] bw_c, mw_c;
    logic [31:0] t_prod;
    logic                     r1_valid;
    logic [15:0]              r1_t;
    logic [pbn_pkg::IN_W-1:0] r1_data;

    always_comb begin
        bw_c = (r_blend_weight > pbn_pkg::WEIGHT_ONE) ? pbn_pkg::WEIGHT_ONE : r_blend_weight;
        mw_c = (i_s_tdata[O_MW +: 16] > pbn_pkg::WEIGHT_ONE) ?
               pbn_pkg::WEIGHT_ONE : i_s_tdata[O_MW +: 16];
        t_prod = bw_c * mw_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_t    <= t_prod[30:15];
            r1_data <= i_s_tdata;
        end
    end

    // ---------------- stage 2: vector products, dot terms ----------------
    logic signed [16:0] t17;
    logic signed [16:0] vd [6];
    logic signed [15:0] va [6];
    logic signed [15:0] qa [4];
    logic signed [15:0] qb [4];

    logic                     r2_valid;
    logic signed [33:0]       r2_pv [6];
    logic signed [15:0]       r2_va [6];
    logic signed [31:0]       r2_dp [4];
    logic signed [15:0]       r2_qa [4];
    logic signed [15:0]       r2_qb [4];
    logic signed [16:0]       r2_t;
    pbn_pkg::t_side           r2_side;

    assign t17 = $signed({1'b0, r1_t});

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            va[k]   = $signed(r1_data[O_AT + k*CW +: CW]);
            va[k+3] = $signed(r1_data[O_AS + k*CW +: CW]);
            vd[k]   = $signed({r1_data[O_BT + k*CW + CW-1], r1_data[O_BT + k*CW +: CW]})
                    - $signed({va[k][15], va[k]});
            vd[k+3] = $signed({r1_data[O_BS + k*CW + CW-1], r1_data[O_BS + k*CW +: CW]})
                    - $signed({va[k+3][15], va[k+3]});
        end
        for (int k = 0; k < 4; k++) begin
            qa[k] = $signed(r1_data[O_AR + k*CW +: CW]);
            qb[k] = $signed(r1_data[O_BR + k*CW +: CW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                r2_pv[k] <= vd[k] * t17;
                r2_va[k] <= va[k];
            end
            for (int k = 0; k < 4; k++) begin
                r2_dp[k] <= qa[k] * qb[k];
                r2_qa[k] <= qa[k];
                r2_qb[k] <= qb[k];
            end
            r2_t <= t17;
            // endpoints copy a whole pose
            r2_side.pass  <= (r1_t == '0) || (r1_t == pbn_pkg::WEIGHT_ONE);
            r2_side.trans <= (r1_t == '0) ? r1_data[O_AT +: VEC_W]  : r1_data[O_BT +: VEC_W];
            r2_side.scale <= (r1_t == '0) ? r1_data[O_AS +: VEC_W]  : r1_data[O_BS +: VEC_W];
            r2_side.prot  <= (r1_t == '0) ? r1_data[O_AR +: QUAT_W] : r1_data[O_BR +: QUAT_W];
        end
    end

    // ---------------- stage 3: vector results, hemisphere fix ----------------
    logic signed [34:0] vr [6];
    logic [VEC_W-1:0]   lt, ls;
    logic signed [33:0] dot;
    logic signed [16:0] bq [4];

    logic               r3_valid;
    logic signed [17:0] r3_dq [4];
    logic signed [15:0] r3_qa [4];
    logic signed [16:0] r3_t;
    pbn_pkg::t_side     r3_side;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            vr[k] = $signed({r2_pv[k][33], r2_pv[k]}) + 35'sd16384;
        end
        for (int k = 0; k < 3; k++) begin
            lt[k*CW +: CW] = vr[k][30:15]   + r2_va[k];
            ls[k*CW +: CW] = vr[k+3][30:15] + r2_va[k+3];
        end
        dot = 34'(r2_dp[0]) + 34'(r2_dp[1]) + 34'(r2_dp[2]) + 34'(r2_dp[3]);
        for (int k = 0; k < 4; k++) begin
            bq[k] = dot[33] ? -$signed({r2_qb[k][15], r2_qb[k]})
                            :  $signed({r2_qb[k][15], r2_qb[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r3_dq[k] <= $signed({bq[k][16], bq[k]})
                          - $signed({{2{r2_qa[k][15]}}, r2_qa[k]});
                r3_qa[k] <= r2_qa[k];
            end
            r3_t          <= r2_t;
            r3_side.pass  <= r2_side.pass;
            r3_side.prot  <= r2_side.prot;
            r3_side.trans <= r2_side.pass ? r2_side.trans : lt;
            r3_side.scale <= r2_side.pass ? r2_side.scale : ls;
        end
    end

    // ---------------- stage 4: quaternion products ----------------
    logic               r4_valid;
    logic signed [34:0] r4_pq [4];
    logic signed [15:0] r4_qa [4];
    pbn_pkg::t_side     r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r4_pq[k] <= r3_dq[k] * r3_t;
                r4_qa[k] <= r3_qa[k];
            end
            r4_side <= r3_side;
        end
    end

    // ---------------- stage 5: quaternion lerp ----------------
    logic signed [35:0] qr [4];
    logic               r5_valid;
    logic signed [17:0] r5_q [4];
    pbn_pkg::t_side     r5_side;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            qr[k] = $signed({r4_pq[k][34], r4_pq[k]}) + 36'sd16384;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r5_q[k] <= $signed(qr[k][32:15]) + $signed({{2{r4_qa[k][15]}}, r4_qa[k]});
            end
            r5_side <= r4_side;
        end
    end

    // ---------------- stage 6: magnitudes and squares ----------------
    logic [17:0] qabs [4];
    logic                 r6_valid;
    logic [MAG_W-1:0]     r6_mag [4];
    logic [3:0]           r6_sign;
    logic [2*MAG_W-1:0]   r6_sq [4];
    pbn_pkg::t_side       r6_side;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            qabs[k] = r5_q[k][17] ? 18'(-r5_q[k]) : 18'(r5_q[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r6_mag[k]  <= qabs[k][MAG_W-1:0];
                r6_sign[k] <= r5_q[k][17];
                r6_sq[k]   <= qabs[k][MAG_W-1:0] * qabs[k][MAG_W-1:0];
            end
            r6_side <= r5_side;
        end
    end

    // ---------------- stage 7: sum of squares ----------------
    logic [SUM_W-1:0]     sum_c;
    logic                 r7_valid;
    logic [SUM_W-1:0]     r7_sum;
    pbn_pkg::t_rot_side   r7_rs;

    assign sum_c = r6_sq[0] + r6_sq[1] + r6_sq[2] + r6_sq[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (en) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sum        <= sum_c;
            r7_rs.side    <= r6_side;
            r7_rs.zero    <= (sum_c == '0);
            r7_rs.sign    <= r6_sign;
            for (int k = 0; k < 4; k++) begin
                r7_rs.mag[k] <= r6_mag[k];
            end
        end
    end

    // ---------------- square root with aligned side data ----------------
    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root;
    pbn_pkg::t_rot_side   sq_rs;

    pbn_isqrt #(
        .IN_W  (SUM_W),
        .OUT_W (ROOT_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_valid),
        .i_x     (r7_sum),
        .o_valid (sq_valid),
        .o_root  (sq_root)
    );

    pbn_delay #(
        .W     (RS_W),
        .DEPTH (ROOT_W)
    ) u_dly_sq (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r7_rs),
        .o_q   (sq_rs)
    );

    // ---------------- stage 8: rounded numerators ----------------
    logic                 r8_valid;
    logic [NUM_W-1:0]     r8_num [4];
    logic [ROOT_W-1:0]    r8_den;
    pbn_pkg::t_rot_side   r8_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (en) begin
            r8_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r8_num[k] <= (NUM_W'(sq_rs.mag[k]) << pbn_pkg::QFRAC)
                           + NUM_W'(sq_root >> 1);
            end
            r8_den <= sq_root;
            r8_rs  <= sq_rs;
        end
    end

    // ---------------- four dividers with aligned side data ----------------
    logic [3:0]           dv_valid;
    logic [QUO_W-1:0]     dv_quo [4];
    pbn_pkg::t_rot_side   dv_rs;

    for (genvar k = 0; k < 4; k++) begin : g_div
        pbn_div #(
            .NUM_W (NUM_W),
            .DEN_W (ROOT_W),
            .QUO_W (QUO_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r8_valid),
            .i_num   (r8_num[k]),
            .i_den   (r8_den),
            .o_valid (dv_valid[k]),
            .o_quo   (dv_quo[k])
        );
    end

    pbn_delay #(
        .W     (RS_W),
        .DEPTH (QUO_W)
    ) u_dly_dv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r8_rs),
        .o_q   (dv_rs)
    );

    // ---------------- output register ----------------
    logic [QUAT_W-1:0]         rot_c;
    logic                      r_out_valid;
    logic [pbn_pkg::OUT_W-1:0] r_out_data;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (dv_rs.zero) begin
                rot_c[k*CW +: CW] = '0;
            end else if (dv_rs.sign[k]) begin
                rot_c[k*CW +: CW] = -CW'(dv_quo[k]);
            end else begin
                rot_c[k*CW +: CW] = CW'(dv_quo[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {dv_rs.side.pass ? dv_rs.side.prot : rot_c,
                           dv_rs.side.scale, dv_rs.side.trans};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // normalized magnitudes never exceed one in Q1.14
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dv_valid[0] && !dv_rs.zero) |->
            (dv_quo[0] <= pbn_pkg::QUO_MAX && dv_quo[1] <= pbn_pkg::QUO_MAX &&
             dv_quo[2] <= pbn_pkg::QUO_MAX && dv_quo[3] <= pbn_pkg::QUO_MAX))
        else $error("normalized component above one");

    // the dividers run in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dv_valid == 4'b0000) || (dv_valid == 4'b1111))
        else $error("divider valid bits disagree");

    // no beat is shown in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
